FILE: rtl/gbnsw_pkg.sv
// gbnsw_pkg: shared types and constants of the go-back-n sender window block
// no dependencies; used by every rtl file of the block but gbnsw_ram

package gbnsw_pkg;

   localparam int SEQ_W   = 16;
   localparam int WIN_W   = 6;
   localparam int LIM_W   = 4;
   localparam int SLOT_OW = 5;
   localparam int KIND_W  = 3;
   localparam int FUNC_W  = 2;
   localparam int CSR_IW  = 2;

   localparam logic [WIN_W-1:0] WIN_MAX      = 6'd32;
   localparam logic [LIM_W-1:0] RETRY_SAT    = 4'd15;
   localparam logic [SEQ_W-1:0] TOTAL_RST    = 16'd1;
   localparam logic [WIN_W-1:0] INIT_WIN_RST = 6'd9;
   localparam logic [LIM_W-1:0] LIMIT_RST    = 4'd10;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_POLL    = 2'd0,
      FUNC_ACK     = 2'd1,
      FUNC_TIMEOUT = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW     = 3'd0,
      KIND_RESEND  = 3'd1,
      KIND_STATUS  = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_GAVE_UP = 3'd4
   } kind_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_TOTAL_FRAMES   = 2'd0,
      CSR_INITIAL_WINDOW = 2'd1,
      CSR_RETRY_LIMIT    = 2'd2,
      CSR_NONE           = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RETRY_CHK,
      ST_RESEND
   } back_state_type;

   // classified command handed from front to back
   typedef struct packed {
      func_type         op;
      logic [SEQ_W-1:0] ack_seq;
      logic [WIN_W-1:0] ack_win;
   } cmd_type;

   // one result item
   typedef struct packed {
      kind_type           kind;
      logic [SEQ_W-1:0]   frame_seq;
      logic [SLOT_OW-1:0] buffer_slot;
      logic [SEQ_W-1:0]   acked_frames;
      logic [WIN_W-1:0]   window;
      logic               last;
   } rsp_type;

   // window values above the maximum count as the maximum
   function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
      clamp_win = (v > WIN_MAX) ? WIN_MAX : v;
   endfunction

endpackage

FILE: rtl/gbnsw_ram.sv
// gbnsw_ram: generic single-write, single-read ram with registered read data
// no dependencies

module gbnsw_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gbnsw_front.sv
// gbnsw_front: accepts request items, decodes and clamps them, queues commands
// depends on gbnsw_pkg

module gbnsw_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,
   input  logic [gbnsw_pkg::FUNC_W-1:0]     req_tuser,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output gbnsw_pkg::cmd_type               cmd
);

   localparam int QDEPTH = 2;

   gbnsw_pkg::cmd_type q_ff [QDEPTH];
   gbnsw_pkg::cmd_type q_in;
   gbnsw_pkg::cmd_type new_cmd;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   // decode func and clamp the advertised window
   always_comb begin
      unique case (req_tuser)
         gbnsw_pkg::FUNC_POLL:    new_cmd.op = gbnsw_pkg::FUNC_POLL;
         gbnsw_pkg::FUNC_ACK:     new_cmd.op = gbnsw_pkg::FUNC_ACK;
         gbnsw_pkg::FUNC_TIMEOUT: new_cmd.op = gbnsw_pkg::FUNC_TIMEOUT;
         default:                 new_cmd.op = gbnsw_pkg::FUNC_UNUSED;
      endcase
      new_cmd.ack_seq = req_tdata[15:0];
      new_cmd.ack_win = gbnsw_pkg::clamp_win(req_tdata[21:16]);
   end

   assign req_tready = (cnt_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];
   assign q_in       = new_cmd;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

FILE: rtl/gbnsw_back.sv
// gbnsw_back: window state, configuration registers and result sequencing
// depends on gbnsw_pkg and gbnsw_ram (per-frame retry counters)

module gbnsw_back #(
   parameter int BUF_FRAMES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  gbnsw_pkg::cmd_type              cmd,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gbnsw_pkg::CSR_IW-1:0]    csr_index,
   input  logic [gbnsw_pkg::SEQ_W-1:0]     csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gbnsw_pkg::rsp_type              rsp
);

   localparam int SLOT_W = $clog2(BUF_FRAMES);
   localparam int SEQ_W  = gbnsw_pkg::SEQ_W;
   localparam int WIN_W  = gbnsw_pkg::WIN_W;
   localparam int LIM_W  = gbnsw_pkg::LIM_W;
   localparam int MODN   = 33;

   gbnsw_pkg::back_state_type state_ff, state_in;
   logic [SEQ_W-1:0]      acked_ff, acked_in;
   logic [SEQ_W-1:0]      sent_ff, sent_in;
   logic [WIN_W-1:0]      win_ff, win_in;
   logic [SLOT_W-1:0]     sent_slot_ff, sent_slot_in;
   logic [SLOT_W-1:0]     acked_slot_ff, acked_slot_in;
   logic                  finished_ff, finished_in;
   logic                  aborted_ff, aborted_in;
   logic [SEQ_W-1:0]      total_ff, total_in;
   logic [WIN_W-1:0]      initwin_ff, initwin_in;
   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic [SEQ_W-1:0]      run_seq_ff, run_seq_in;
   logic [SLOT_W-1:0]     run_slot_ff, run_slot_in;
   logic [WIN_W-1:0]      run_left_ff, run_left_in;
   logic [SLOT_W-1:0]     retry_idx_ff, retry_idx_in;
   logic [BUF_FRAMES-1:0] retry_vld_ff, retry_vld_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   gbnsw_pkg::rsp_type    rsp_ff, rsp_in;

   logic [SLOT_W-1:0]     mod_tab [MODN];
   logic                  out_free;
   logic                  fin_now;
   logic [SEQ_W:0]        next_seq;
   logic [WIN_W-1:0]      ack_dist;
   logic [SLOT_W-1:0]     ack_mod;
   logic [SLOT_W-1:0]     ack_slot;
   logic [SEQ_W-1:0]      left_frames;
   logic [WIN_W-1:0]      outstanding;
   logic [WIN_W-1:0]      run_count;
   logic [LIM_W-1:0]      cnt_old, cnt_new;
   logic                  ram_wr, ram_rd;
   logic [LIM_W-1:0]      ram_rdata;

   // small constants of d mod BUF_FRAMES for distances up to the window maximum
   for (genvar g = 0; g < MODN; g++) begin : g_mod
      assign mod_tab[g] = SLOT_W'(g % BUF_FRAMES);
   end

   gbnsw_ram #(
      .WIDTH (LIM_W),
      .DEPTH (BUF_FRAMES)
   ) u_retry_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (retry_idx_ff),
      .wr_data (cnt_new),
      .rd_en   (ram_rd),
      .rd_addr (retry_idx_in),
      .rd_data (ram_rdata)
   );

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == SLOT_W'(BUF_FRAMES - 1)) ? '0 : s + 1'b1;
   endfunction

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign cmd_ready = (state_ff == gbnsw_pkg::ST_IDLE) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

   // acknowledgment arithmetic
   always_comb begin
      next_seq = {1'b0, cmd.ack_seq} + 1'b1;
      ack_dist = WIN_W'(sent_ff - next_seq[SEQ_W-1:0]);
      ack_mod  = mod_tab[ack_dist];
      if (sent_slot_ff >= ack_mod) begin
         ack_slot = sent_slot_ff - ack_mod;
      end else begin
         ack_slot = SLOT_W'({1'b0, sent_slot_ff} + (SLOT_W+1)'(BUF_FRAMES) - {1'b0, ack_mod});
      end
      left_frames = total_ff - acked_ff;
      outstanding = WIN_W'(sent_ff - acked_ff);
      run_count   = (outstanding < win_ff) ? outstanding : win_ff;
      cnt_old     = retry_vld_ff[retry_idx_ff] ? ram_rdata : '0;
      cnt_new     = (cnt_old == gbnsw_pkg::RETRY_SAT) ? cnt_old : cnt_old + 1'b1;
      fin_now     = finished_ff || (!aborted_ff && (acked_ff >= total_ff));
   end

   always_comb begin
      state_in      = state_ff;
      acked_in      = acked_ff;
      sent_in       = sent_ff;
      win_in        = win_ff;
      sent_slot_in  = sent_slot_ff;
      acked_slot_in = acked_slot_ff;
      finished_in   = finished_ff;
      aborted_in    = aborted_ff;
      total_in      = total_ff;
      initwin_in    = initwin_ff;
      limit_in      = limit_ff;
      run_seq_in    = run_seq_ff;
      run_slot_in   = run_slot_ff;
      run_left_in   = run_left_ff;
      retry_idx_in  = retry_idx_ff;
      retry_vld_in  = retry_vld_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ram_wr        = 1'b0;
      ram_rd        = 1'b0;

      rsp_in.frame_seq    = rsp_ff.frame_seq;
      rsp_in.acked_frames = rsp_ff.acked_frames;

      unique case (state_ff)
         gbnsw_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.kind         = gbnsw_pkg::KIND_STATUS;
               rsp_in.frame_seq    = '0;
               rsp_in.buffer_slot  = '0;
               rsp_in.acked_frames = acked_ff;
               rsp_in.window       = win_ff;
               rsp_in.last         = 1'b1;
               finished_in         = fin_now && !aborted_ff;
               if (aborted_ff) begin
                  rsp_in.kind = gbnsw_pkg::KIND_GAVE_UP;
               end else if (fin_now) begin
                  rsp_in.kind = gbnsw_pkg::KIND_DONE;
               end else begin
                  unique case (cmd.op)
                     gbnsw_pkg::FUNC_POLL: begin
                        if (({1'b0, sent_ff} < {1'b0, acked_ff} + (SEQ_W+1)'(win_ff)) &&
                            (sent_ff < total_ff)) begin
                           rsp_in.kind        = gbnsw_pkg::KIND_NEW;
                           rsp_in.frame_seq   = sent_ff;
                           rsp_in.buffer_slot = gbnsw_pkg::SLOT_OW'(sent_slot_ff);
                           sent_in            = sent_ff + 1'b1;
                           sent_slot_in       = slot_inc(sent_slot_ff);
                        end
                     end
                     gbnsw_pkg::FUNC_ACK: begin
                        if (cmd.ack_seq < sent_ff) begin
                           // zero window or a repeat of the newest ack: window only
                           if (win_ff == '0 || next_seq[SEQ_W-1:0] == acked_ff) begin
                              win_in = cmd.ack_win;
                           end else if (next_seq[SEQ_W-1:0] > acked_ff) begin
                              acked_in      = next_seq[SEQ_W-1:0];
                              acked_slot_in = ack_slot;
                              win_in        = cmd.ack_win;
                           end
                        end
                        rsp_in.acked_frames = acked_in;
                        rsp_in.window       = win_in;
                        if (acked_in >= total_ff) begin
                           finished_in = 1'b1;
                           rsp_in.kind = gbnsw_pkg::KIND_DONE;
                        end
                     end
                     gbnsw_pkg::FUNC_TIMEOUT: begin
                        if (left_frames < SEQ_W'(BUF_FRAMES)) begin
                           // one of the final frames: check its retry counter first
                           rsp_vld_in   = 1'b0;
                           retry_idx_in = SLOT_W'(BUF_FRAMES - 1) - SLOT_W'(left_frames);
                           ram_rd       = 1'b1;
                           state_in     = gbnsw_pkg::ST_RETRY_CHK;
                        end else if (run_count != '0) begin
                           rsp_vld_in  = 1'b0;
                           run_seq_in  = acked_ff;
                           run_slot_in = acked_slot_ff;
                           run_left_in = run_count;
                           state_in    = gbnsw_pkg::ST_RESEND;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         gbnsw_pkg::ST_RETRY_CHK: begin
            if (out_free) begin
               ram_wr                     = 1'b1;
               retry_vld_in[retry_idx_ff] = 1'b1;
               if (cnt_new >= limit_ff) begin
                  aborted_in          = 1'b1;
                  rsp_vld_in          = 1'b1;
                  rsp_in.kind         = gbnsw_pkg::KIND_GAVE_UP;
                  rsp_in.frame_seq    = '0;
                  rsp_in.buffer_slot  = '0;
                  rsp_in.acked_frames = acked_ff;
                  rsp_in.window       = win_ff;
                  rsp_in.last         = 1'b1;
                  state_in            = gbnsw_pkg::ST_IDLE;
               end else if (run_count == '0) begin
                  rsp_vld_in          = 1'b1;
                  rsp_in.kind         = gbnsw_pkg::KIND_STATUS;
                  rsp_in.frame_seq    = '0;
                  rsp_in.buffer_slot  = '0;
                  rsp_in.acked_frames = acked_ff;
                  rsp_in.window       = win_ff;
                  rsp_in.last         = 1'b1;
                  state_in            = gbnsw_pkg::ST_IDLE;
               end else begin
                  run_seq_in  = acked_ff;
                  run_slot_in = acked_slot_ff;
                  run_left_in = run_count;
                  state_in    = gbnsw_pkg::ST_RESEND;
               end
            end
         end
         gbnsw_pkg::ST_RESEND: begin
            if (out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.kind         = gbnsw_pkg::KIND_RESEND;
               rsp_in.frame_seq    = run_seq_ff;
               rsp_in.buffer_slot  = gbnsw_pkg::SLOT_OW'(run_slot_ff);
               rsp_in.acked_frames = acked_ff;
               rsp_in.window       = win_ff;
               rsp_in.last         = (run_left_ff == WIN_W'(1));
               run_seq_in          = run_seq_ff + 1'b1;
               run_slot_in         = slot_inc(run_slot_ff);
               run_left_in         = run_left_ff - 1'b1;
               if (run_left_ff == WIN_W'(1)) begin
                  state_in = gbnsw_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = gbnsw_pkg::ST_IDLE;
         end
      endcase

      // register writes are for the user to give only while idle; the block itself does not enforce it
      if (csr_valid) begin
         unique case (gbnsw_pkg::csr_index_type'(csr_index))
            gbnsw_pkg::CSR_TOTAL_FRAMES: total_in = csr_wdata;
            gbnsw_pkg::CSR_INITIAL_WINDOW: begin
               initwin_in = gbnsw_pkg::clamp_win(csr_wdata[WIN_W-1:0]);
               win_in     = initwin_in;
            end
            gbnsw_pkg::CSR_RETRY_LIMIT: limit_in = csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gbnsw_pkg::ST_IDLE;
         acked_ff      <= '0;
         sent_ff       <= '0;
         win_ff        <= gbnsw_pkg::INIT_WIN_RST;
         sent_slot_ff  <= '0;
         acked_slot_ff <= '0;
         finished_ff   <= 1'b0;
         aborted_ff    <= 1'b0;
         total_ff      <= gbnsw_pkg::TOTAL_RST;
         initwin_ff    <= gbnsw_pkg::INIT_WIN_RST;
         limit_ff      <= gbnsw_pkg::LIMIT_RST;
         run_left_ff   <= '0;
         retry_vld_ff  <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acked_ff      <= acked_in;
         sent_ff       <= sent_in;
         win_ff        <= win_in;
         sent_slot_ff  <= sent_slot_in;
         acked_slot_ff <= acked_slot_in;
         finished_ff   <= finished_in;
         aborted_ff    <= aborted_in;
         total_ff      <= total_in;
         initwin_ff    <= initwin_in;
         limit_ff      <= limit_in;
         run_left_ff   <= run_left_in;
         retry_vld_ff  <= retry_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      run_seq_ff   <= run_seq_in;
      run_slot_ff  <= run_slot_in;
      retry_idx_ff <= retry_idx_in;
      rsp_ff       <= rsp_in;
   end

endmodule

FILE: rtl/go_back_n_sender_window_top.sv
// go_back_n_sender_window_top: go-back-n sender window control, top level
// depends on gbnsw_pkg, gbnsw_front, gbnsw_back (which holds gbnsw_ram)
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   req     | in        | req_tvalid/req_tready | tuser func, tdata ack_seq/ack_window
//   rsp     | out       | rsp_tvalid/rsp_tready | tuser kind, tlast last, tdata rest
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// poll, ack and unused codes are answered straight from idle; a timeout first reads a
// final frame's retry counter from ram when one is due, then gives up or resends up to
// 32 frames, paced by the resend sequencer and held while a result waits on rsp_tready
// reset (synchronous, active high) clears the window state and the retry valid bits
// a two-item command queue lets requests enter while a result waits on rsp_tready

module go_back_n_sender_window_top #(
   parameter int BUF_FRAMES = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // request items
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,  // ack_seq[15:0], ack_window[21:16], zero
   input  logic [gbnsw_pkg::FUNC_W-1:0] req_tuser,  // func[1:0]
   // result items
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata,  // frame_seq[15:0], buffer_slot[20:16],
                                                    // acked_frames[36:21], window[42:37], zero
   output logic [gbnsw_pkg::KIND_W-1:0] rsp_tuser,  // kind[2:0]
   output logic                         rsp_tlast,
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gbnsw_pkg::CSR_IW-1:0] csr_index,
   input  logic [gbnsw_pkg::SEQ_W-1:0]  csr_wdata
);

   // handoff between the classifying front and the executing back
   logic               cmd_valid;
   logic               cmd_ready;
   gbnsw_pkg::cmd_type cmd;
   gbnsw_pkg::rsp_type rsp;

   gbnsw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   gbnsw_back #(
      .BUF_FRAMES (BUF_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // result item packing, lowest field first
   assign rsp_tdata = {5'd0, rsp.window, rsp.acked_frames, rsp.buffer_slot, rsp.frame_seq};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

FILE: rtl/gbnsw_checker.sv
// gbnsw_checker: port-level checks of the go-back-n sender window block
// depends on gbnsw_pkg; bound to go_back_n_sender_window_top

module gbnsw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [47:0]                  rsp_tdata,
   input logic [gbnsw_pkg::KIND_W-1:0] rsp_tuser,
   input logic                         rsp_tlast
);

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // only resend runs have more than one result per item
   a_multi_is_resend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == gbnsw_pkg::KIND_W'(gbnsw_pkg::KIND_RESEND))
      else $error("non-final result that is not a resend");

   // status, done and gave-up results carry no frame
   a_status_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == gbnsw_pkg::KIND_W'(gbnsw_pkg::KIND_STATUS) ||
                     rsp_tuser == gbnsw_pkg::KIND_W'(gbnsw_pkg::KIND_DONE) ||
                     rsp_tuser == gbnsw_pkg::KIND_W'(gbnsw_pkg::KIND_GAVE_UP))
      |-> rsp_tlast && rsp_tdata[20:0] == 21'd0)
      else $error("status result with frame fields set");

endmodule

bind go_back_n_sender_window_top gbnsw_checker u_checker (.*);

FILE: bench/tb_go_back_n_sender_window_top.sv
// tb_go_back_n_sender_window_top: self-checking bench for the go-back-n sender window block
// depends on gbnsw_pkg and go_back_n_sender_window_top; polls, acks and timeouts are
// streamed in, and every result item is checked against a local window predictor

`timescale 1ns / 100ps

module tb_go_back_n_sender_window_top;

   localparam int FRAMES      = 32;    // frame buffer depth, also the longest resend run
   localparam int QUIET_LIMIT = 1000;  // cycles without any handshake before giving up
   localparam int SEQ_W       = gbnsw_pkg::SEQ_W;
   localparam int WIN_W       = gbnsw_pkg::WIN_W;
   localparam int LIM_W       = gbnsw_pkg::LIM_W;
   localparam int SLOT_OW     = gbnsw_pkg::SLOT_OW;
   localparam int KIND_W      = gbnsw_pkg::KIND_W;
   localparam int FUNC_W      = gbnsw_pkg::FUNC_W;
   localparam int CSR_IW      = gbnsw_pkg::CSR_IW;

   // one request item as the block sees it
   typedef struct packed {
      gbnsw_pkg::func_type func;
      logic [SEQ_W-1:0]    ack_seq;
      logic [WIN_W-1:0]    ack_window;
   } sender_event_type;

   // window state plus the register copies it depends on
   typedef struct packed {
      logic [31:0]                  acked;
      logic [31:0]                  sent;
      logic [WIN_W-1:0]             win;
      logic [FRAMES-1:0][LIM_W-1:0] retry;
      logic                         done;
      logic                         gave_up;
      logic [SEQ_W-1:0]             total;
      logic [WIN_W-1:0]             init_win;
      logic [LIM_W-1:0]             limit;
   } sender_state_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic [FUNC_W-1:0]    req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;
   logic [KIND_W-1:0]    rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IW-1:0]    csr_index;
   logic [SEQ_W-1:0]     csr_wdata;

   // sender_now follows accepted items, sender_plan runs ahead while items are queued
   sender_state_type     sender_now;
   sender_state_type     sender_plan;
   sender_event_type     pending_events [$];
   gbnsw_pkg::rsp_type   due_results [$];
   sender_event_type     event_on_bus;

   bit                   req_idle_on;
   bit                   rsp_idle_on;
   int                   send_gap;
   int                   rsp_stall;
   int                   quiet_cycles;
   int                   mismatches;
   int                   events_taken;
   int                   results_taken;
   int                   kind_hits [5];

   go_back_n_sender_window_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // window predictor
   // ------------------------------------------------------------------

   function automatic sender_state_type reset_state();
      sender_state_type s;
      s          = '0;
      s.total    = gbnsw_pkg::TOTAL_RST;
      s.init_win = gbnsw_pkg::INIT_WIN_RST;
      s.limit    = gbnsw_pkg::LIMIT_RST;
      s.win      = gbnsw_pkg::INIT_WIN_RST;
      return s;
   endfunction

   // frame number and slot only travel with send and resend items
   function automatic gbnsw_pkg::rsp_type make_result(input sender_state_type s,
                                                      input gbnsw_pkg::kind_type k,
                                                      input logic [31:0] seq,
                                                      input logic fin);
      gbnsw_pkg::rsp_type r;
      logic [31:0]        slot;
      r      = '0;
      r.kind = k;
      slot   = seq % FRAMES;
      if (k == gbnsw_pkg::KIND_NEW || k == gbnsw_pkg::KIND_RESEND) begin
         r.frame_seq   = seq[SEQ_W-1:0];
         r.buffer_slot = slot[SLOT_OW-1:0];
      end
      r.acked_frames = s.acked[SEQ_W-1:0];
      r.window       = s.win;
      r.last         = fin;
      return r;
   endfunction

   // register writes land in the state copy; a window write also reloads the window
   function automatic void apply_csr(inout sender_state_type s,
                                     input gbnsw_pkg::csr_index_type idx,
                                     input logic [SEQ_W-1:0] v);
      case (idx)
         gbnsw_pkg::CSR_TOTAL_FRAMES: begin
            s.total = v;
         end
         gbnsw_pkg::CSR_INITIAL_WINDOW: begin
            s.init_win = (v[WIN_W-1:0] > gbnsw_pkg::WIN_MAX) ? gbnsw_pkg::WIN_MAX :
                                                               v[WIN_W-1:0];
            s.win      = s.init_win;
         end
         gbnsw_pkg::CSR_RETRY_LIMIT: begin
            s.limit = v[LIM_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // advances the window state by one request item, returns how many results it gives
   function automatic int window_step(inout sender_state_type s, input sender_event_type ev,
                                      output gbnsw_pkg::rsp_type res [FRAMES]);
      logic [WIN_W-1:0] adv;
      logic [31:0]      nxt;
      logic [31:0]      outst;
      logic [31:0]      run;
      logic [31:0]      slot_idx;
      adv = (ev.ack_window > gbnsw_pkg::WIN_MAX) ? gbnsw_pkg::WIN_MAX : ev.ack_window;
      // completion is noticed lazily, even after a total register write
      if (!s.done && !s.gave_up && s.acked >= s.total)
         s.done = 1'b1;
      if (s.gave_up) begin
         res[0] = make_result(s, gbnsw_pkg::KIND_GAVE_UP, 0, 1'b1);
         return 1;
      end
      if (s.done) begin
         res[0] = make_result(s, gbnsw_pkg::KIND_DONE, 0, 1'b1);
         return 1;
      end
      case (ev.func)
         gbnsw_pkg::FUNC_POLL: begin
            // new frame only with the window open and frames left
            if (s.sent < s.acked + s.win && s.sent < s.total) begin
               res[0] = make_result(s, gbnsw_pkg::KIND_NEW, s.sent, 1'b1);
               s.sent = s.sent + 1;
            end else begin
               res[0] = make_result(s, gbnsw_pkg::KIND_STATUS, 0, 1'b1);
            end
            return 1;
         end
         gbnsw_pkg::FUNC_ACK: begin
            // acks of frames never sent are dropped, stale acks fall through
            if (ev.ack_seq < s.sent) begin
               nxt = ev.ack_seq + 32'd1;
               if (s.win == '0) begin
                  s.win = adv;
               end else if (nxt == s.acked) begin
                  s.win = adv;
               end else if (nxt > s.acked) begin
                  s.acked = nxt;
                  s.win   = adv;
               end
            end
            if (s.acked >= s.total) begin
               s.done = 1'b1;
               res[0] = make_result(s, gbnsw_pkg::KIND_DONE, 0, 1'b1);
            end else begin
               res[0] = make_result(s, gbnsw_pkg::KIND_STATUS, 0, 1'b1);
            end
            return 1;
         end
         gbnsw_pkg::FUNC_TIMEOUT: begin
            // near the end of the session each timeout is charged to one retry counter
            if (s.acked + FRAMES > s.total) begin
               slot_idx = (s.acked + FRAMES - s.total - 1) % FRAMES;
               if (s.retry[slot_idx] < gbnsw_pkg::RETRY_SAT)
                  s.retry[slot_idx] = s.retry[slot_idx] + 1'b1;
               if (s.retry[slot_idx] >= s.limit) begin
                  s.gave_up = 1'b1;
                  res[0]    = make_result(s, gbnsw_pkg::KIND_GAVE_UP, 0, 1'b1);
                  return 1;
               end
            end
            outst = (s.sent > s.acked) ? s.sent - s.acked : 32'd0;
            run   = (outst < s.win) ? outst : 32'(s.win);
            if (run > FRAMES)
               run = FRAMES;
            if (run == 0) begin
               res[0] = make_result(s, gbnsw_pkg::KIND_STATUS, 0, 1'b1);
               return 1;
            end
            for (int i = 0; i < run; i++)
               res[i] = make_result(s, gbnsw_pkg::KIND_RESEND, s.acked + i, i == run - 1);
            return int'(run);
         end
         default: begin
            res[0] = make_result(s, gbnsw_pkg::KIND_STATUS, 0, 1'b1);
            return 1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // request driver: one item at a time from pending_events, random gaps
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive_events
      gbnsw_pkg::rsp_type fresh [FRAMES];
      int                 n;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         // prediction happens when the block takes the item
         if (req_tvalid && req_tready) begin
            n = window_step(sender_now, event_on_bus, fresh);
            for (int i = 0; i < n; i++)
               due_results.push_back(fresh[i]);
            events_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               event_on_bus = pending_events.pop_front();
               req_tdata  <= {2'b00, event_on_bus.ack_window, event_on_bus.ack_seq};
               req_tuser  <= event_on_bus.func;
               req_tvalid <= 1'b1;
               send_gap   <= req_idle_on ? int'($urandom_range(0, 3)) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: compares each result with the oldest due one
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want_v);
      mismatches++;
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_taken, what, got, want_v);
   endtask

   always @(posedge clock) begin : check_results
      gbnsw_pkg::rsp_type want;
      int                 hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_taken++;
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result, kind", int'(rsp_tuser), -1);
            end else begin
               want = due_results.pop_front();
               kind_hits[want.kind]++;
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", int'(rsp_tuser), int'(want.kind));
               if (rsp_tdata[15:0] !== want.frame_seq)
                  report_mismatch("frame_seq", int'(rsp_tdata[15:0]), int'(want.frame_seq));
               if (rsp_tdata[20:16] !== want.buffer_slot)
                  report_mismatch("buffer_slot", int'(rsp_tdata[20:16]),
                                  int'(want.buffer_slot));
               if (rsp_tdata[36:21] !== want.acked_frames)
                  report_mismatch("acked_frames", int'(rsp_tdata[36:21]),
                                  int'(want.acked_frames));
               if (rsp_tdata[42:37] !== want.window)
                  report_mismatch("window", int'(rsp_tdata[42:37]), int'(want.window));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", int'(rsp_tlast), int'(want.last));
            end
            // randomly stall the result side after this item when result idling is on
            hold = rsp_idle_on ? int'($urandom_range(0, 3)) : 0;
            if (hold == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               rsp_stall  <= hold - 1;
            end
         end else if (!rsp_tready) begin
            if (rsp_stall == 0)
               rsp_tready <= 1'b1;
            else
               rsp_stall <= rsp_stall - 1;
         end
      end
   end

   // watchdog: no handshake on any channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results still due",
                  QUIET_LIMIT, due_results.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // queue one item and run it through the planning copy of the state
   task automatic push_event(input gbnsw_pkg::func_type f, input logic [SEQ_W-1:0] seq,
                             input logic [WIN_W-1:0] w);
      sender_event_type   ev;
      gbnsw_pkg::rsp_type scratch [FRAMES];
      ev.func       = f;
      ev.ack_seq    = seq;
      ev.ack_window = w;
      void'(window_step(sender_plan, ev, scratch));
      pending_events.push_back(ev);
   endtask

   // fields that the operation ignores still get random bits
   task automatic push_plain(input gbnsw_pkg::func_type f);
      push_event(f, SEQ_W'($urandom_range(0, 65535)), WIN_W'($urandom_range(0, 63)));
   endtask

   // advertised window: mostly legal, sometimes closed, sometimes above the maximum
   function automatic logic [WIN_W-1:0] pick_window();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return WIN_W'($urandom_range(1, 32));
      else if (r < 90)
         return '0;
      else
         return WIN_W'($urandom_range(33, 63));
   endfunction

   // random traffic shaped by the planned state so acks mostly hit outstanding frames
   task automatic push_random(input int count);
      int               r;
      int unsigned      lo;
      logic [SEQ_W-1:0] seq;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            push_plain(gbnsw_pkg::FUNC_POLL);
         end else if (r < 75) begin
            r = $urandom_range(0, 99);
            if (sender_plan.sent == 0 || r >= 88) begin
               // ack of a frame not sent yet
               seq = SEQ_W'($urandom_range(sender_plan.sent, 65535));
            end else if (r >= 76 && sender_plan.acked >= 2) begin
               // stale ack well below the acked edge
               seq = SEQ_W'($urandom_range(0, sender_plan.acked - 2));
            end else begin
               // duplicate or advancing ack
               lo  = (sender_plan.acked > 0) ? sender_plan.acked - 1 : 0;
               seq = SEQ_W'($urandom_range(lo, sender_plan.sent - 1));
            end
            push_event(gbnsw_pkg::FUNC_ACK, seq, pick_window());
         end else if (r < 92) begin
            push_plain(gbnsw_pkg::FUNC_TIMEOUT);
         end else if (r < 96) begin
            push_plain(gbnsw_pkg::FUNC_UNUSED);
         end else begin
            // noise: random operation with random fields
            push_plain(gbnsw_pkg::func_type'($urandom_range(0, 3)));
         end
      end
   endtask

   // register write; only called with the block idle
   task automatic csr_write(input gbnsw_pkg::csr_index_type idx, input logic [SEQ_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(sender_plan, idx, v);
      apply_csr(sender_now, idx, v);
   endtask

   // sender holds off until every due result is back, then a short settle
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = gbnsw_pkg::CSR_TOTAL_FRAMES;
      csr_wdata   = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      sender_now  = reset_state();
      sender_plan = reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: single-frame session, window 9
      push_event(gbnsw_pkg::FUNC_POLL, 16'd0, 6'd0);         // sends frame 0
      push_event(gbnsw_pkg::FUNC_POLL, 16'hffff, 6'd63);     // no frames left
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);                   // counted timeout, resends frame 0
      push_event(gbnsw_pkg::FUNC_UNUSED, 16'hffff, 6'd63);   // unused code
      push_event(gbnsw_pkg::FUNC_ACK, 16'hffff, 6'd63);      // ack of an unsent frame
      push_event(gbnsw_pkg::FUNC_ACK, 16'd1, 6'd0);          // same, window field zero
      wait_idle();

      // long session, window closed, highest retry limit
      csr_write(gbnsw_pkg::CSR_TOTAL_FRAMES, 16'hffff);
      csr_write(gbnsw_pkg::CSR_RETRY_LIMIT, {12'($urandom_range(0, 4095)), 4'd15});
      csr_write(gbnsw_pkg::CSR_INITIAL_WINDOW, {10'($urandom_range(0, 1023)), 6'd0});
      csr_write(gbnsw_pkg::CSR_NONE, 16'($urandom_range(0, 65535)));

      push_event(gbnsw_pkg::FUNC_POLL, 16'd0, 6'd0);         // closed window
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);                   // outstanding frame, window zero
      push_event(gbnsw_pkg::FUNC_ACK, 16'd0, 6'd63);         // zero window: only sets window
      push_event(gbnsw_pkg::FUNC_ACK, 16'd0, 6'd20);         // advances acked edge
      push_event(gbnsw_pkg::FUNC_POLL, 16'd0, 6'd0);
      push_event(gbnsw_pkg::FUNC_POLL, 16'd0, 6'd0);
      push_event(gbnsw_pkg::FUNC_ACK, 16'd0, 6'd7);          // duplicate ack refreshes window
      push_event(gbnsw_pkg::FUNC_ACK, 16'd2, 6'd32);         // jumps the acked edge
      push_event(gbnsw_pkg::FUNC_ACK, 16'd0, 6'd5);          // stale ack
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);                   // nothing outstanding
      push_plain(gbnsw_pkg::FUNC_POLL);
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);                   // one-frame resend
      push_event(gbnsw_pkg::FUNC_ACK, 16'd3, 6'd0);          // window closes on ack
      push_plain(gbnsw_pkg::FUNC_POLL);                      // closed window again
      push_event(gbnsw_pkg::FUNC_ACK, 16'd3, 6'd40);         // reopens, clamped to maximum
      push_random(20);
      wait_idle();

      // full window, then a maximum-length resend run with no idling on either side
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      csr_write(gbnsw_pkg::CSR_INITIAL_WINDOW, {10'($urandom_range(0, 1023)), 6'd63});
      while (sender_plan.sent < sender_plan.acked + sender_plan.win &&
             sender_plan.sent < sender_plan.total)
         push_plain(gbnsw_pkg::FUNC_POLL);
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);
      push_random(20);
      wait_idle();

      // small window with idling back on
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      csr_write(gbnsw_pkg::CSR_INITIAL_WINDOW, 16'd5);
      push_random(20);
      wait_idle();

      // session end close by: timeouts are counted, low retry limit
      csr_write(gbnsw_pkg::CSR_TOTAL_FRAMES, 16'(sender_plan.acked + 12));
      csr_write(gbnsw_pkg::CSR_RETRY_LIMIT, {12'($urandom_range(0, 4095)), 4'd3});
      push_random(20);
      wait_idle();

      // zero retry limit: the next counted timeout gives up
      csr_write(gbnsw_pkg::CSR_RETRY_LIMIT, {12'($urandom_range(0, 4095)), 4'd0});
      push_plain(gbnsw_pkg::FUNC_TIMEOUT);
      push_plain(gbnsw_pkg::FUNC_POLL);
      wait_idle();

      // zero total: finished on the next item unless already given up
      csr_write(gbnsw_pkg::CSR_TOTAL_FRAMES, 16'd0);
      csr_write(gbnsw_pkg::CSR_INITIAL_WINDOW, 16'd32);
      push_event(gbnsw_pkg::FUNC_ACK, 16'd0, 6'd1);
      push_plain(gbnsw_pkg::FUNC_POLL);
      wait_idle();

      $display("run covered %0d request items and %0d result items, %0d mismatches",
               events_taken, results_taken, mismatches);
      $display("results by kind new/resend/status/done/gave up: %0d/%0d/%0d/%0d/%0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4]);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
